// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the drive mixer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied
`define DCMW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define DCMW_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dcmw_pkg.sv =====
// Package for the drive command mixer: codes, register limits, command and config types.
// Used by every module of the block; depends on nothing.
package dcmw_pkg;

	// Default parameter values
	localparam int unsigned TICK_COUNTER_WIDTH_DEF = 16;
	localparam int unsigned QUEUE_DEPTH_DEF        = 2;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 21;

	localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SCALE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WHEEL_BASE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TURNS_PER_METER = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WHEEL_SPEED = 3'd5;

	// Register limits and reset values
	localparam logic [10:0] SENS_MIN      = 11'd10;
	localparam logic [10:0] SENS_MAX      = 11'd1024;
	localparam logic [10:0] SENS_RST      = 11'd102;
	localparam logic [10:0] SCALE_MIN     = 11'd51;
	localparam logic [10:0] SCALE_MAX     = 11'd1024;
	localparam logic [10:0] SCALE_RST     = 11'd1024;
	localparam logic [15:0] TIMEOUT_MIN   = 16'd1;
	localparam logic [15:0] TIMEOUT_RST   = 16'd400;
	localparam logic [15:0] HWB_RST       = 16'd14090;
	localparam logic [15:0] TPM_RST       = 16'd6862;
	localparam logic [20:0] SPEED_MAX     = 21'd1048576;
	localparam logic [20:0] SPEED_RST     = 21'd131072;

	// Input mode codes
	localparam logic [2:0] MODE_TWIST   = 3'd0;
	localparam logic [2:0] MODE_FORWARD = 3'd1;
	localparam logic [2:0] MODE_BACK    = 3'd2;
	localparam logic [2:0] MODE_LEFT    = 3'd3;
	localparam logic [2:0] MODE_RIGHT   = 3'd4;
	localparam logic [2:0] MODE_STOP    = 3'd5;
	localparam logic [2:0] MODE_TICK    = 3'd6;

	// Result action codes
	localparam logic [1:0] ACT_VELOCITY = 2'd0;
	localparam logic [1:0] ACT_POSITION = 2'd1;
	localparam logic [1:0] ACT_STOP     = 2'd2;

	// Step arithmetic: rounding offset for the divide by 80 and reciprocal of 5 (Q.21)
	localparam logic [22:0] STEP_ROUND  = 23'd40;
	localparam logic [12:0] STEP_BIAS   = 13'd1024;
	localparam logic [11:0] TURN_BIAS   = 12'd512;
	localparam logic [18:0] RECIP_FIVE  = 19'd419431;

	typedef enum logic [1:0] {
		CMD_TWIST,
		CMD_MOVE,
		CMD_STOP
	} cmd_kind_t;

	// Classified item handed from the front end to the back end
	typedef struct packed {
		cmd_kind_t          kind;
		logic               ent;
		logic [2:0]         mode;
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		logic [31:0]        p0;
		logic [31:0]        p1;
	} cmd_t;

	// Registers read by the back end
	typedef struct packed {
		logic [10:0] sensitivity;
		logic [10:0] step_scale;
		logic [15:0] half_wheel_base;
		logic [15:0] turns_per_meter;
		logic [20:0] max_wheel_speed;
	} drive_cfg_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MULD,
		BK_SUM,
		BK_MULL,
		BK_CLPL,
		BK_MULR,
		BK_CLPR,
		BK_SCALE,
		BK_RECIP,
		BK_MOVE,
		BK_DONE
	} bk_state_t;

endpackage

// ===== rtl/dcmw_front.sv =====
// Front end: accepts items, keeps the watchdog and mode flags, classifies into commands.
// Depends on dcmw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcmw_front #(
	parameter int unsigned TICK_COUNTER_WIDTH = dcmw_pkg::TICK_COUNTER_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        timeout_ticks,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [15:0] linear_velocity,
	input  logic signed [15:0] angular_velocity,
	input  logic signed [31:0] axis0_position,
	input  logic signed [31:0] axis1_position,
	input  logic               q_full,
	output logic               push,
	output dcmw_pkg::cmd_t     push_cmd
);
	import dcmw_pkg::*;

	localparam int unsigned TW = TICK_COUNTER_WIDTH;

	logic          twist_active_q, twist_active_d;
	logic          vel_mode_q, vel_mode_d;
	logic [TW-1:0] ticks_q, ticks_d;
	logic [TW:0]   tick_next;
	logic          fire;
	logic          accept;
	logic          push_req;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign tick_next = {1'b0, ticks_q} + (TW+1)'(1);
	assign fire      = twist_active_q && (33'(tick_next) > 33'(timeout_ticks));
	assign push      = accept && push_req;

	// Classify the item and work out the flag updates
	always_comb begin
		push_cmd       = '0;
		push_cmd.kind  = CMD_STOP;
		push_cmd.mode  = mode;
		push_cmd.lin   = linear_velocity;
		push_cmd.ang   = angular_velocity;
		push_cmd.p0    = axis0_position;
		push_cmd.p1    = axis1_position;
		push_req       = 1'b0;
		twist_active_d = twist_active_q;
		vel_mode_d     = vel_mode_q;
		ticks_d        = ticks_q;
		unique case (mode)
			MODE_TWIST: begin
				push_cmd.kind  = CMD_TWIST;
				push_cmd.ent   = !vel_mode_q;
				push_req       = 1'b1;
				twist_active_d = 1'b1;
				vel_mode_d     = 1'b1;
				ticks_d        = '0;
			end
			MODE_FORWARD, MODE_BACK, MODE_LEFT, MODE_RIGHT: begin
				push_cmd.kind  = CMD_MOVE;
				push_req       = 1'b1;
				twist_active_d = 1'b0;
				vel_mode_d     = 1'b0;
			end
			MODE_STOP: begin
				push_req       = 1'b1;
				twist_active_d = 1'b0;
				vel_mode_d     = 1'b0;
			end
			MODE_TICK: begin
				// count up, saturating at all ones
				ticks_d = tick_next[TW] ? '1 : tick_next[TW-1:0];
				if (fire) begin
					push_req       = 1'b1;
					twist_active_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Update flags and watchdog count on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twist_active_q <= 1'b0;
			vel_mode_q     <= 1'b0;
			ticks_q        <= '0;
		end else if (accept) begin
			twist_active_q <= twist_active_d;
			vel_mode_q     <= vel_mode_d;
			ticks_q        <= ticks_d;
		end
	end

	`DCMW_ASSERT(a_twist_rearms, (accept && mode == MODE_TWIST) |=> (ticks_q == '0 && twist_active_q && vel_mode_q), "twist did not rearm the watchdog")

endmodule

// ===== rtl/dcmw_fifo.sv =====
// Short command queue between front and back end, held in flip-flops.
// Depends on dcmw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcmw_fifo #(
	parameter int unsigned DEPTH = dcmw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dcmw_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output dcmw_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import dcmw_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_q];

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DCMW_ASSERT(a_fifo_no_overflow, !(push && full), "push into a full queue")
	`DCMW_ASSERT(a_fifo_no_underflow, !(pop && empty), "pop from an empty queue")
	`DCMW_ASSERT(a_fifo_count_bound, (count_q <= CW'(DEPTH)), "queue count beyond depth")

endmodule

// ===== rtl/dcmw_back.sv =====
// Back end: sequences twist mixing and manual steps through one shared multiplier.
// Depends on dcmw_pkg and assert_macros.svh; drives the output register.
`include "assert_macros.svh"

module dcmw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcmw_pkg::drive_cfg_t cfg,
	input  logic                 q_empty,
	output logic                 pop,
	input  dcmw_pkg::cmd_t       cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           action,
	output logic                 enter_velocity_mode,
	output logic signed [31:0]   axis0_value,
	output logic signed [31:0]   axis1_value
);
	import dcmw_pkg::*;

	bk_state_t          state_q, state_d;
	cmd_t               cmd_q;
	logic signed [54:0] prod_q;
	logic signed [33:0] left_q, right_q;
	logic [31:0]        ax0_q, ax1_q;

	logic               out_valid_q;
	logic [1:0]         action_q;
	logic               ent_q;
	logic [31:0]        out0_q, out1_q;

	logic signed [33:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [54:0] mul_p;
	logic               mul_en;
	logic               load_out;
	logic               slot_free;
	logic signed [33:0] base;
	logic [12:0]        step_base;
	logic [11:0]        turn_base;
	logic [22:0]        round_sum;
	logic [31:0]        delta;

	// Floor the Q.40 product to Q16.16 and clamp to the speed limit
	function automatic logic signed [31:0] clamp_speed(input logic signed [54:0] p,
			input logic [20:0] lim);
		logic signed [31:0] t;
		logic signed [31:0] hi;
		t  = 32'($signed(p[54:24]));
		hi = $signed({11'b0, lim});
		if (t > hi) begin
			return hi;
		end else if (t < -hi) begin
			return -hi;
		end
		return t;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign mul_p     = mul_a * mul_b;
	assign base      = $signed({{2{cmd_q.lin[15]}}, cmd_q.lin, 16'h0000});
	assign step_base = STEP_BIAS + {cfg.sensitivity, 2'b00};
	assign turn_base = TURN_BIAS + 12'(cfg.sensitivity);
	assign round_sum = prod_q[22:0] + STEP_ROUND;
	assign delta     = 32'(prod_q[37:21]);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					unique case (cmd.kind)
						CMD_TWIST: state_d = BK_MULD;
						CMD_MOVE:  state_d = BK_SCALE;
						default:   state_d = BK_DONE;
					endcase
				end
			end
			BK_MULD:  state_d = BK_SUM;
			BK_SUM:   state_d = BK_MULL;
			BK_MULL:  state_d = BK_CLPL;
			BK_CLPL:  state_d = BK_MULR;
			BK_MULR:  state_d = BK_CLPR;
			BK_CLPR:  state_d = BK_DONE;
			BK_SCALE: state_d = BK_RECIP;
			BK_RECIP: state_d = BK_MOVE;
			BK_MOVE:  state_d = BK_DONE;
			BK_DONE: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	// State outputs: queue pop, multiplier operands, output load
	always_comb begin
		pop      = 1'b0;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !q_empty;
			BK_MULD: begin
				mul_en = 1'b1;
				mul_a  = 34'(cmd_q.ang);
				mul_b  = $signed({5'b0, cfg.half_wheel_base});
			end
			BK_MULL: begin
				mul_en = 1'b1;
				mul_a  = left_q;
				mul_b  = $signed({5'b0, cfg.turns_per_meter});
			end
			BK_MULR: begin
				mul_en = 1'b1;
				mul_a  = right_q;
				mul_b  = $signed({5'b0, cfg.turns_per_meter});
			end
			BK_SCALE: begin
				mul_en = 1'b1;
				if (cmd_q.mode == MODE_FORWARD || cmd_q.mode == MODE_BACK) begin
					mul_a = $signed(34'(step_base));
				end else begin
					mul_a = $signed(34'(turn_base));
				end
				mul_b = $signed({10'b0, cfg.step_scale});
			end
			BK_RECIP: begin
				// divide by 16 then by 5 through the reciprocal
				mul_en = 1'b1;
				mul_a  = $signed(34'(round_sum[22:4]));
				mul_b  = $signed({2'b0, RECIP_FIVE});
			end
			BK_DONE: load_out = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
			ax0_q <= '0;
			ax1_q <= '0;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		if (state_q == BK_SUM) begin
			left_q  <= base - prod_q[33:0];
			right_q <= base + prod_q[33:0];
		end
		if (state_q == BK_CLPL) begin
			ax1_q <= clamp_speed(prod_q, cfg.max_wheel_speed);
		end
		if (state_q == BK_CLPR) begin
			ax0_q <= -clamp_speed(prod_q, cfg.max_wheel_speed);
		end
		if (state_q == BK_MOVE) begin
			unique case (cmd_q.mode)
				MODE_FORWARD: begin
					ax0_q <= cmd_q.p0 - delta;
					ax1_q <= cmd_q.p1 + delta;
				end
				MODE_BACK: begin
					ax0_q <= cmd_q.p0 + delta;
					ax1_q <= cmd_q.p1 - delta;
				end
				MODE_LEFT: begin
					ax0_q <= cmd_q.p0 - delta;
					ax1_q <= cmd_q.p1 - delta;
				end
				default: begin
					ax0_q <= cmd_q.p0 + delta;
					ax1_q <= cmd_q.p1 + delta;
				end
			endcase
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			unique case (cmd_q.kind)
				CMD_TWIST: action_q <= ACT_VELOCITY;
				CMD_MOVE:  action_q <= ACT_POSITION;
				default:   action_q <= ACT_STOP;
			endcase
			ent_q  <= (cmd_q.kind == CMD_TWIST) && cmd_q.ent;
			out0_q <= ax0_q;
			out1_q <= ax1_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign action              = action_q;
	assign enter_velocity_mode = ent_q;
	assign axis0_value         = $signed(out0_q);
	assign axis1_value         = $signed(out1_q);

	`DCMW_ASSERT(a_stop_zero, (out_valid && action == ACT_STOP) |-> (axis0_value == '0 && axis1_value == '0), "stop result with nonzero axis values")
	`DCMW_ASSERT(a_ent_twist_only, (out_valid && enter_velocity_mode) |-> (action == ACT_VELOCITY), "velocity mode entry flagged on a non-twist result")

endmodule

// ===== rtl/drive_command_mixer_watchdog.sv =====
// Top level of the differential drive command mixer with twist watchdog.
// Depends on dcmw_pkg, dcmw_front, dcmw_fifo and dcmw_back; holds the config registers.

// The front end takes one item per cycle while its command queue (QUEUE_DEPTH entries) has
// room; a tick that does not trip the watchdog, or an unused mode code, ends there with no
// result. Every other item is carried out by the back end one at a time, with every multiply
// on a single shared multiplier: a twist goes through queue pop, six multiply, mix and clamp
// steps and output load; a move through queue pop, scale and reciprocal multiplies, position
// update and output load; a stop or watchdog stop through queue pop and output load. Results
// wait in an output register, so the back end works on the next item while one is unclaimed,
// until its output load. Configuration writes saturate to the legal range and are taken at once.
module drive_command_mixer_watchdog #(
	parameter int unsigned TICK_COUNTER_WIDTH = dcmw_pkg::TICK_COUNTER_WIDTH_DEF,
	parameter int unsigned QUEUE_DEPTH        = dcmw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [dcmw_pkg::CFG_INDEX_W-1:0] cfg_addr,
	input  logic [dcmw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       mode,
	input  logic signed [15:0]               linear_velocity,
	input  logic signed [15:0]               angular_velocity,
	input  logic signed [31:0]               axis0_position,
	input  logic signed [31:0]               axis1_position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       action,
	output logic                             enter_velocity_mode,
	output logic signed [31:0]               axis0_value,
	output logic signed [31:0]               axis1_value
);
	import dcmw_pkg::*;

	drive_cfg_t  cfg_q;
	logic [15:0] timeout_q;
	logic [10:0] wd11;
	logic [15:0] wd16;
	logic [20:0] wd21;

	logic q_full, q_empty, push, pop;
	cmd_t push_cmd, pop_cmd;

	assign wd11 = cfg_wdata[10:0];
	assign wd16 = cfg_wdata[15:0];
	assign wd21 = cfg_wdata[20:0];

	// Write configuration registers, saturating to range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensitivity     <= SENS_RST;
			cfg_q.step_scale      <= SCALE_RST;
			cfg_q.half_wheel_base <= HWB_RST;
			cfg_q.turns_per_meter <= TPM_RST;
			cfg_q.max_wheel_speed <= SPEED_RST;
			timeout_q             <= TIMEOUT_RST;
		end else if (cfg_write) begin
			unique case (cfg_addr)
				CFG_SENSITIVITY: begin
					cfg_q.sensitivity <= (wd11 < SENS_MIN) ? SENS_MIN :
						(wd11 > SENS_MAX) ? SENS_MAX : wd11;
				end
				CFG_STEP_SCALE: begin
					cfg_q.step_scale <= (wd11 < SCALE_MIN) ? SCALE_MIN :
						(wd11 > SCALE_MAX) ? SCALE_MAX : wd11;
				end
				CFG_TIMEOUT_TICKS: begin
					timeout_q <= (wd16 < TIMEOUT_MIN) ? TIMEOUT_MIN : wd16;
				end
				CFG_HALF_WHEEL_BASE: cfg_q.half_wheel_base <= wd16;
				CFG_TURNS_PER_METER: cfg_q.turns_per_meter <= wd16;
				CFG_MAX_WHEEL_SPEED: begin
					cfg_q.max_wheel_speed <= (wd21 > SPEED_MAX) ? SPEED_MAX : wd21;
				end
				default: begin
				end
			endcase
		end
	end

	dcmw_front #(
		.TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.timeout_ticks    (timeout_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.axis0_position   (axis0_position),
		.axis1_position   (axis1_position),
		.q_full           (q_full),
		.push             (push),
		.push_cmd         (push_cmd)
	);

	dcmw_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	dcmw_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.q_empty             (q_empty),
		.pop                 (pop),
		.cmd                 (pop_cmd),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.action              (action),
		.enter_velocity_mode (enter_velocity_mode),
		.axis0_value         (axis0_value),
		.axis1_value         (axis1_value)
	);

endmodule

// ===== tb/tb_drive_command_mixer_watchdog.sv =====
// Self-checking testbench for drive_command_mixer_watchdog: drives twist, manual, stop and tick
// items with random idling on both channels and checks every result against a local predictor.
// Depends on dcmw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_drive_command_mixer_watchdog;
	import dcmw_pkg::*;

	localparam logic [2:0] MODE_UNUSED  = 3'd7;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         QUIET_LIMIT   = 2000;

	// Expected wheel command for one item
	typedef struct packed {
		logic [1:0]  action;
		logic        enter_vel;
		logic [31:0] axis0;
		logic [31:0] axis1;
	} wheel_cmd_t;

	// Tracks registers and drive state, predicts wheel commands and checks results in order
	class mixer_checker;
		logic [10:0] sens;
		logic [10:0] scale;
		logic [15:0] tmo;
		logic [15:0] half_base;
		logic [15:0] tpm;
		logic [20:0] speed_lim;
		logic        watching;
		logic        in_vel_mode;
		logic [15:0] ticks;
		wheel_cmd_t  awaited[$];
		int          failures;

		function new();
			sens        = SENS_RST;
			scale       = SCALE_RST;
			tmo         = TIMEOUT_RST;
			half_base   = HWB_RST;
			tpm         = TPM_RST;
			speed_lim   = SPEED_RST;
			watching    = 1'b0;
			in_vel_mode = 1'b0;
			ticks       = '0;
			failures    = 0;
		endfunction

		// Clamp each write to the legal range of its register
		function void set_register(input logic [2:0] idx, input logic [20:0] val);
			case (idx)
				CFG_SENSITIVITY: begin
					sens = (val[10:0] < SENS_MIN) ? SENS_MIN :
						(val[10:0] > SENS_MAX) ? SENS_MAX : val[10:0];
				end
				CFG_STEP_SCALE: begin
					scale = (val[10:0] < SCALE_MIN) ? SCALE_MIN :
						(val[10:0] > SCALE_MAX) ? SCALE_MAX : val[10:0];
				end
				CFG_TIMEOUT_TICKS: tmo = (val[15:0] == 16'd0) ? TIMEOUT_MIN : val[15:0];
				CFG_HALF_WHEEL_BASE: half_base = val[15:0];
				CFG_TURNS_PER_METER: tpm = val[15:0];
				CFG_MAX_WHEEL_SPEED: speed_lim = (val > SPEED_MAX) ? SPEED_MAX : val;
				default: ;
			endcase
		endfunction

		// Ground speed in Q.28 m/s to clamped wheel speed in Q16.16 turns/s, floor rounding
		function longint wheel_turns(input longint ground_q28);
			longint t;
			longint lim;
			t = (ground_q28 * longint'(tpm)) >>> 24;
			lim = longint'(speed_lim);
			if (t > lim)
				t = lim;
			if (t < -lim)
				t = -lim;
			return t;
		endfunction

		// Advance the drive state for one accepted item and queue its command, if any
		function void take_command(input logic [2:0] m, input logic signed [15:0] lin,
			input logic signed [15:0] ang, input logic [31:0] p0, input logic [31:0] p1);
			wheel_cmd_t  want;
			longint      ground;
			longint      spin;
			longint      left;
			longint      right;
			logic [31:0] step;
			logic [31:0] turn;
			logic [16:0] nxt;
			want = '0;
			case (m)
				MODE_TWIST: begin
					ground = longint'(lin) * 65536;
					spin = longint'(ang) * longint'(half_base);
					left = wheel_turns(ground - spin);
					right = -wheel_turns(ground + spin);
					want.action = ACT_VELOCITY;
					want.enter_vel = !in_vel_mode;
					want.axis0 = right[31:0];
					want.axis1 = left[31:0];
					in_vel_mode = 1'b1;
					watching = 1'b1;
					ticks = '0;
					awaited.push_back(want);
				end
				MODE_FORWARD, MODE_BACK, MODE_LEFT, MODE_RIGHT: begin
					step = ((32'd1024 + 32'd4 * sens) * scale + 32'd40) / 32'd80;
					turn = ((32'd512 + sens) * scale + 32'd40) / 32'd80;
					watching = 1'b0;
					in_vel_mode = 1'b0;
					want.action = ACT_POSITION;
					case (m)
						MODE_FORWARD: begin
							want.axis0 = p0 - step;
							want.axis1 = p1 + step;
						end
						MODE_BACK: begin
							want.axis0 = p0 + step;
							want.axis1 = p1 - step;
						end
						MODE_LEFT: begin
							want.axis0 = p0 - turn;
							want.axis1 = p1 - turn;
						end
						default: begin
							want.axis0 = p0 + turn;
							want.axis1 = p1 + turn;
						end
					endcase
					awaited.push_back(want);
				end
				MODE_STOP: begin
					watching = 1'b0;
					in_vel_mode = 1'b0;
					want.action = ACT_STOP;
					awaited.push_back(want);
				end
				MODE_TICK: begin
					// compare before saturating, so a full counter can still trip
					nxt = {1'b0, ticks} + 17'd1;
					ticks = nxt[16] ? 16'hFFFF : nxt[15:0];
					if (watching && nxt > {1'b0, tmo}) begin
						watching = 1'b0;
						want.action = ACT_STOP;
						awaited.push_back(want);
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one result with the oldest expected command
		function void match_result(input logic [1:0] act, input logic ent,
			input logic [31:0] a0, input logic [31:0] a1);
			wheel_cmd_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: action %0d axis0 %h axis1 %h", act, a0, a1);
				failures++;
			end else begin
				want = awaited.pop_front();
				if (act !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, act);
					failures++;
				end
				if (ent !== want.enter_vel) begin
					$error("enter_velocity_mode: expected %0d, got %0d", want.enter_vel, ent);
					failures++;
				end
				if (a0 !== want.axis0) begin
					$error("axis0_value: expected %h, got %h", want.axis0, a0);
					failures++;
				end
				if (a1 !== want.axis1) begin
					$error("axis1_value: expected %h, got %h", want.axis1, a1);
					failures++;
				end
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              mode = MODE_TWIST;
	logic signed [15:0]      linear_velocity = '0;
	logic signed [15:0]      angular_velocity = '0;
	logic signed [31:0]      axis0_position = '0;
	logic signed [31:0]      axis1_position = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              action;
	logic                    enter_velocity_mode;
	logic signed [31:0]      axis0_value;
	logic signed [31:0]      axis1_value;

	mixer_checker board = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	drive_command_mixer_watchdog u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result channel in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 15);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.match_result(action, enter_velocity_mode, axis0_value, axis1_value);
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one item, hold it until accepted, then hand it to the predictor
	task automatic send_item(input logic [2:0] m, input logic [15:0] lin, input logic [15:0] ang,
		input logic [31:0] p0, input logic [31:0] p1);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		linear_velocity <= lin;
		angular_velocity <= ang;
		axis0_position <= p0;
		axis1_position <= p1;
		do @(posedge clk); while (!in_ready);
		board.take_command(m, lin, ang, p0, p1);
	endtask

	// Velocity with a bias toward the extremes and small magnitudes
	function automatic logic [15:0] pick_vel();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 8192)) :
				-16'($urandom_range(0, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(input logic [2:0] m);
		send_item(m, pick_vel(), pick_vel(), pick_pos(), pick_pos());
	endtask

	// Drop valid and wait until the block has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
		cfg_write <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.set_register(idx, val);
	endtask

	task automatic apply_setting(input logic [20:0] sens, input logic [20:0] scale,
		input logic [20:0] tmo, input logic [20:0] hwb, input logic [20:0] tpm,
		input logic [20:0] speed);
		write_reg(CFG_SENSITIVITY, sens);
		write_reg(CFG_STEP_SCALE, scale);
		write_reg(CFG_TIMEOUT_TICKS, tmo);
		write_reg(CFG_HALF_WHEEL_BASE, hwb);
		write_reg(CFG_TURNS_PER_METER, tpm);
		write_reg(CFG_MAX_WHEEL_SPEED, speed);
		cfg_write <= 1'b0;
	endtask

	// Mostly twist-then-ticks sequences that exercise the watchdog, mixed with moves and stops
	task automatic run_traffic(input int n_items);
		int sent;
		int pick;
		int ticks_n;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_random(MODE_TWIST);
				sent++;
				ticks_n = (board.tmo <= 20) ? $urandom_range(0, board.tmo + 2) :
					$urandom_range(0, 6);
				repeat (ticks_n) begin
					send_random(MODE_TICK);
					sent++;
				end
			end else if (pick < 65) begin
				send_random(3'($urandom_range(MODE_FORWARD, MODE_RIGHT)));
				sent++;
			end else if (pick < 75) begin
				send_random(MODE_STOP);
				sent++;
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 3)) begin
					send_random(MODE_TICK);
					sent++;
				end
			end else if (pick < 95) begin
				send_random(MODE_TWIST);
				send_random(MODE_TWIST);
				sent += 2;
			end else begin
				send_random(MODE_UNUSED);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every mode, enter flag after reset, manual and stop
		stall_pct = 20;
		send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_TWIST, 16'h0000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_TWIST, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 32'h0);
		send_item(MODE_TWIST, 16'h8000, 16'h7FFF, 32'h0, 32'hFFFF_FFFF);
		send_item(MODE_TWIST, 16'h1000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_TWIST, 16'hFFFF, 16'h0001, 32'h0, 32'h0);
		send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_FORWARD, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(MODE_BACK, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(MODE_LEFT, 16'h0000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_RIGHT, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(MODE_TWIST, 16'h0800, 16'hF800, 32'h0, 32'h0);
		send_item(MODE_STOP, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(MODE_TWIST, 16'hF000, 16'h0400, 32'h0, 32'h0);
		send_item(MODE_UNUSED, 16'h1234, 16'h4321, 32'h1, 32'h2);
		send_item(MODE_TWIST, 16'h0400, 16'hFC00, 32'h0, 32'h0);

		// Directed watchdog trip: third tick after a twist, then velocity mode is kept
		settle();
		write_reg(CFG_TIMEOUT_TICKS, 21'd2);
		cfg_write <= 1'b0;
		send_item(MODE_TWIST, 16'h2000, 16'h0400, 32'h0, 32'h0);
		repeat (4) send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
		send_item(MODE_TWIST, 16'hE000, 16'h0000, 32'h0, 32'h0);

		// Reset values
		settle();
		apply_setting(SENS_RST, SCALE_RST, TIMEOUT_RST, HWB_RST, TPM_RST, SPEED_RST);
		gap_pct = 25;
		stall_pct = 25;
		run_traffic(110);

		// Lower limits
		settle();
		apply_setting(SENS_MIN, SCALE_MIN, TIMEOUT_MIN, 21'd0, 21'd0, 21'd0);
		gap_pct = 50;
		stall_pct = 10;
		run_traffic(90);

		// Upper limits
		settle();
		apply_setting(SENS_MAX, SCALE_MAX, 21'hFFFF, 21'hFFFF, 21'hFFFF, SPEED_MAX);
		gap_pct = 10;
		stall_pct = 50;
		run_traffic(90);

		// Out-of-range writes saturate; writes to unused indexes change nothing
		settle();
		apply_setting(21'd0, 21'h1FFFFF, 21'd0, 21'h1F0000 | 21'($urandom),
			21'h1F0000 | 21'($urandom), 21'h1FFFFF);
		write_reg(3'd6, 21'($urandom));
		write_reg(3'd7, 21'($urandom));
		cfg_write <= 1'b0;
		gap_pct = 30;
		stall_pct = 30;
		run_traffic(90);

		// Random settings with short timeouts and varying pressure
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			apply_setting(21'($urandom_range(SENS_MIN, SENS_MAX)),
				21'($urandom_range(SCALE_MIN, SCALE_MAX)), 21'($urandom_range(1, 12)),
				21'($urandom), 21'($urandom), 21'($urandom_range(0, SPEED_MAX)));
			case (ph)
				0: begin
					gap_pct = 15;
					stall_pct = 40;
				end
				1: begin
					gap_pct = 40;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 15;
				end
				default: begin
					// final stretch runs without idling
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			run_traffic(90);
		end

		// Drain and report
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
